/* hw/rtl/bitmap_rect_fill_and_rotate_defines.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the pixel grid block
// Shared property templates, clocked on i_clk, disabled during reset.
// ----------------------------------------------------------------------------
`ifndef BITMAP_RECT_FILL_AND_ROTATE_DEFINES_SVH
`define BITMAP_RECT_FILL_AND_ROTATE_DEFINES_SVH

// same-cycle implication
`define BRFR_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define BRFR_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hw/rtl/brfr_pkg.sv */
// ----------------------------------------------------------------------------
// brfr_pkg
// Types and constants shared by the pixel grid controller and datapath.
// ----------------------------------------------------------------------------
package brfr_pkg;

    localparam int GRID_WIDTH_DEF  = 50;
    localparam int GRID_HEIGHT_DEF = 6;

    localparam int ACT_W = 2;
    localparam int ARG_W = 6;
    localparam int LIT_W = 9;

    localparam logic [LIT_W-1:0] LIT_MAX = 9'd511;

    typedef enum logic [ACT_W-1:0] {
        ACT_RECT    = 2'd0,
        ACT_ROT_ROW = 2'd1,
        ACT_ROT_COL = 2'd2
    } t_action;

    typedef enum logic [2:0] {
        S_IDLE,
        S_REDUCE,
        S_LOAD,
        S_PASS,
        S_DONE
    } t_state;

    typedef struct packed {
        logic load;       // capture request
        logic reduce;     // reduce shift amount modulo rotate length
        logic load_col;   // capture rotated column, clear count, reset row index
        logic pass_step;  // process head row and rotate the row ring
        logic out_load;   // latch saturated count into output register
    } t_cmd;

    typedef struct packed {
        logic last_row;   // row index at last row
    } t_sts;

endpackage

/* hw/rtl/brfr_ctrl.sv */
// ----------------------------------------------------------------------------
// brfr_ctrl
// Sequencer for one request: reduce shift amount, load column, row pass, output.
// ----------------------------------------------------------------------------
module brfr_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    input  brfr_pkg::t_sts i_sts,
    output brfr_pkg::t_cmd o_cmd
);
    import brfr_pkg::*;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) n_state = S_REDUCE;
            end
            S_REDUCE: begin
                n_state = S_LOAD;
            end
            S_LOAD: begin
                n_state = S_PASS;
            end
            S_PASS: begin
                if (i_sts.last_row) n_state = S_DONE;
            end
            S_DONE: begin
                if (!r_out_valid || !i_out_stall) n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_cmd       = '0;
        n_out_valid = r_out_valid && i_out_stall;
        unique case (r_state)
            S_IDLE: begin
                o_cmd.load = i_in_valid;
            end
            S_REDUCE: begin
                o_cmd.reduce = 1'b1;
            end
            S_LOAD: begin
                o_cmd.load_col = 1'b1;
            end
            S_PASS: begin
                o_cmd.pass_step = 1'b1;
            end
            S_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    o_cmd.out_load = 1'b1;
                    n_out_valid    = 1'b1;
                end
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

/* hw/rtl/brfr_dp.sv */
// ----------------------------------------------------------------------------
// brfr_dp
// Pixel row ring, per-row update logic, lit counter and output register.
// ----------------------------------------------------------------------------
module brfr_dp #(
    parameter int GRID_WIDTH  = brfr_pkg::GRID_WIDTH_DEF,
    parameter int GRID_HEIGHT = brfr_pkg::GRID_HEIGHT_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  brfr_pkg::t_cmd              i_cmd,
    input  logic [brfr_pkg::ACT_W-1:0]  i_action,
    input  logic [brfr_pkg::ARG_W-1:0]  i_first_arg,
    input  logic [brfr_pkg::ARG_W-1:0]  i_second_arg,
    output brfr_pkg::t_sts              o_sts,
    output logic [brfr_pkg::LIT_W-1:0]  o_lit_count
);
    import brfr_pkg::*;

    localparam int YW = $clog2(GRID_HEIGHT);
    localparam int CW = $clog2(GRID_WIDTH * GRID_HEIGHT + 1);
    localparam int SW = (CW > LIT_W) ? CW : LIT_W;
    localparam int LW = ARG_W + 1;
    localparam int RW = 2 * ARG_W + 1;

    logic [GRID_WIDTH-1:0]  r_rows [GRID_HEIGHT];
    logic [ACT_W-1:0]       r_act;
    logic [ARG_W-1:0]       r_a;
    logic [ARG_W-1:0]       r_b;
    logic [ARG_W-1:0]       r_amt;
    logic [GRID_HEIGHT-1:0] r_col;
    logic [YW-1:0]          r_y;
    logic [CW-1:0]          r_cnt;
    logic [LIT_W-1:0]       r_lit;

    logic [LW-1:0]          len;
    logic [ARG_W-1:0]       amt_mod;
    logic [GRID_WIDTH-1:0]  xmask;
    logic [GRID_WIDTH-1:0]  rmask;
    logic [GRID_HEIGHT-1:0] colvec;
    logic [GRID_HEIGHT-1:0] col_rot;
    logic [GRID_WIDTH-1:0]  head;
    logic [GRID_WIDTH-1:0]  row_rot;
    logic [GRID_WIDTH-1:0]  new_row;
    logic [SW-1:0]          cnt_ext;

    // restoring remainder, one compare and subtract per shifted length
    function automatic logic [ARG_W-1:0] mod_len(input logic [ARG_W-1:0] v,
                                                 input logic [LW-1:0]    l);
        logic [RW-1:0] rem;
        logic [RW-1:0] dvs;
        rem = {{(ARG_W+1){1'b0}}, v};
        for (int k = ARG_W - 1; k >= 0; k--) begin
            dvs = {{ARG_W{1'b0}}, l} << k;
            if (rem >= dvs) rem = rem - dvs;
        end
        return rem[ARG_W-1:0];
    endfunction

    assign len     = (r_act == ACT_ROT_COL) ? LW'(GRID_HEIGHT) : LW'(GRID_WIDTH);
    assign amt_mod = mod_len(r_b, len);
    assign o_sts.last_row = (r_y == YW'(GRID_HEIGHT - 1));

    assign xmask = {{(GRID_WIDTH-1){1'b0}}, 1'b1} << r_a;

    always_comb begin
        for (int b = 0; b < GRID_WIDTH; b++) begin
            rmask[b] = (LW'(b) < {1'b0, r_a});
        end
        for (int i = 0; i < GRID_HEIGHT; i++) begin
            colvec[i] = |(r_rows[i] & xmask);
        end
    end

    assign col_rot = (colvec << r_amt) | (colvec >> (LW'(GRID_HEIGHT) - {1'b0, r_amt}));
    assign head    = r_rows[0];
    assign row_rot = (head << r_amt) | (head >> (LW'(GRID_WIDTH) - {1'b0, r_amt}));

    always_comb begin
        new_row = head;
        unique case (r_act)
            ACT_RECT: begin
                if (LW'(r_y) < {1'b0, r_b}) new_row = head | rmask;
            end
            ACT_ROT_ROW: begin
                if (LW'(r_y) == {1'b0, r_a}) new_row = row_rot;
            end
            ACT_ROT_COL: begin
                new_row = (head & ~xmask) | (xmask & {GRID_WIDTH{r_col[0]}});
            end
            default: begin
                new_row = head;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < GRID_HEIGHT; i++) begin
                r_rows[i] <= '0;
            end
            r_y <= '0;
        end else begin
            if (i_cmd.load_col) begin
                r_y <= '0;
            end else if (i_cmd.pass_step) begin
                for (int i = 0; i < GRID_HEIGHT - 1; i++) begin
                    r_rows[i] <= r_rows[i+1];
                end
                r_rows[GRID_HEIGHT-1] <= new_row;
                r_y <= r_y + YW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_act <= i_action;
            r_a   <= i_first_arg;
            r_b   <= i_second_arg;
        end
        if (i_cmd.reduce) begin
            r_amt <= amt_mod;
        end
        if (i_cmd.load_col) begin
            r_col <= col_rot;
            r_cnt <= '0;
        end else if (i_cmd.pass_step) begin
            r_col <= {1'b0, r_col[GRID_HEIGHT-1:1]};
            r_cnt <= r_cnt + CW'($countones(new_row));
        end
        if (i_cmd.out_load) begin
            r_lit <= (cnt_ext > SW'(LIT_MAX)) ? LIT_MAX : cnt_ext[LIT_W-1:0];
        end
    end

    assign cnt_ext     = SW'(r_cnt);
    assign o_lit_count = r_lit;

endmodule

/* hw/rtl/bitmap_rect_fill_and_rotate.sv */
// ----------------------------------------------------------------------------
// bitmap_rect_fill_and_rotate
// Monochrome pixel grid with rectangle fill and row/column rotate requests.
// ----------------------------------------------------------------------------
// Input channel i_in_valid / o_in_stall carries one request (action, first and
// second argument). Output channel o_out_valid / i_out_stall returns the number
// of lit pixels after that request, saturated at 511.
// A request is taken only while the sequencer is idle. The sequencer then
// reduces the shift amount modulo the rotate length, captures the rotated
// column, passes every row once through the update and popcount logic, and
// loads the output register; only then can it take the next request.
// The output register holds its result while i_out_stall is high; the next
// request may be taken meanwhile, and its result waits in the final step
// until the register is free.
// Reset clears every pixel and empties the output register.
// ----------------------------------------------------------------------------
module bitmap_rect_fill_and_rotate #(
    parameter int GRID_WIDTH  = brfr_pkg::GRID_WIDTH_DEF,
    parameter int GRID_HEIGHT = brfr_pkg::GRID_HEIGHT_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic [brfr_pkg::ACT_W-1:0]  i_action,
    input  logic [brfr_pkg::ARG_W-1:0]  i_first_arg,
    input  logic [brfr_pkg::ARG_W-1:0]  i_second_arg,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic [brfr_pkg::LIT_W-1:0]  o_lit_count
);
    import brfr_pkg::*;

    `include "bitmap_rect_fill_and_rotate_defines.svh"

    t_cmd cmd;
    t_sts sts;

    brfr_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    brfr_dp #(
        .GRID_WIDTH  (GRID_WIDTH),
        .GRID_HEIGHT (GRID_HEIGHT)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .i_action     (i_action),
        .i_first_arg  (i_first_arg),
        .i_second_arg (i_second_arg),
        .o_sts        (sts),
        .o_lit_count  (o_lit_count)
    );

    `BRFR_ASSERT_NXT(a_busy_after_accept, i_in_valid && !o_in_stall, o_in_stall, "not busy")
    `BRFR_ASSERT_IMP(a_no_overwrite, cmd.out_load, !o_out_valid || !i_out_stall, "result overwritten")
    `BRFR_ASSERT_NXT(a_result_shown, cmd.out_load, o_out_valid && !o_in_stall, "result not shown")
    `BRFR_ASSERT_IMP(a_load_when_idle, cmd.load, !o_in_stall, "request captured while busy")

endmodule

/* tb/pixel_count_checker.sv */
// ----------------------------------------------------------------------------
// pixel_count_checker
// Tracks the pixel grid from every accepted request and checks each returned
// lit count, in order, against the count it predicts.
// ----------------------------------------------------------------------------
module pixel_count_checker
    import brfr_pkg::*;
#(
    parameter int GRID_WIDTH  = GRID_WIDTH_DEF,
    parameter int GRID_HEIGHT = GRID_HEIGHT_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic             i_in_stall,
    input  logic [ACT_W-1:0] i_action,
    input  logic [ARG_W-1:0] i_first_arg,
    input  logic [ARG_W-1:0] i_second_arg,
    input  logic             i_out_valid,
    input  logic             i_out_stall,
    input  logic [LIT_W-1:0] i_lit_count,
    output int               o_fail_count,
    output int               o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [GRID_WIDTH-1:0] grid [GRID_HEIGHT];
    logic [LIT_W-1:0]      expected_counts [$];
    int                    mismatch_count = 0;

    assign o_fail_count = mismatch_count;

    task automatic report_mismatch(input string msg);
        $display("[%0t] ERROR: %s", $realtime, msg);
        mismatch_count++;
    endtask

    // applies one request to the grid copy and returns the lit count after it
    function automatic logic [LIT_W-1:0] apply_command(input logic [ACT_W-1:0] act,
                                                       input logic [ARG_W-1:0] a,
                                                       input logic [ARG_W-1:0] b);
        logic [GRID_WIDTH-1:0]  fill_mask;
        logic [GRID_WIDTH-1:0]  row_bits;
        logic [GRID_HEIGHT-1:0] col_bits;
        int                     n;
        int                     total;
        fill_mask = '0;
        total     = 0;
        case (act)
            ACT_RECT: begin
                // clamping falls out of the range compares
                for (int x = 0; x < GRID_WIDTH; x++) fill_mask[x] = (x < a);
                for (int y = 0; y < GRID_HEIGHT; y++) begin
                    if (y < b) grid[y] = grid[y] | fill_mask;
                end
            end
            ACT_ROT_ROW: begin
                if (a < GRID_HEIGHT) begin
                    n = b % GRID_WIDTH;
                    if (n != 0) begin
                        row_bits = grid[a];
                        grid[a]  = (row_bits << n) | (row_bits >> (GRID_WIDTH - n));
                    end
                end
            end
            ACT_ROT_COL: begin
                if (a < GRID_WIDTH) begin
                    n = b % GRID_HEIGHT;
                    if (n != 0) begin
                        for (int y = 0; y < GRID_HEIGHT; y++) col_bits[y] = grid[y][a];
                        for (int y = 0; y < GRID_HEIGHT; y++) begin
                            grid[y][a] = col_bits[(y + GRID_HEIGHT - n) % GRID_HEIGHT];
                        end
                    end
                end
            end
            default: ;
        endcase
        for (int y = 0; y < GRID_HEIGHT; y++) total += $countones(grid[y]);
        return (total > LIT_MAX) ? LIT_MAX : total[LIT_W-1:0];
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int y = 0; y < GRID_HEIGHT; y++) grid[y] = '0;
            expected_counts.delete();
            o_pending <= 0;
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (expected_counts.size() == 0) begin
                    report_mismatch($sformatf("unexpected lit_count %0d", i_lit_count));
                end else if (i_lit_count !== expected_counts[0]) begin
                    report_mismatch($sformatf("lit_count got %0d, expected %0d",
                                              i_lit_count, expected_counts[0]));
                    void'(expected_counts.pop_front());
                end else begin
                    void'(expected_counts.pop_front());
                end
            end
            if (i_in_valid && !i_in_stall) begin
                expected_counts.push_back(apply_command(i_action, i_first_arg, i_second_arg));
            end
            o_pending <= expected_counts.size();
        end
    end

endmodule

/* tb/bitmap_rect_fill_and_rotate_tb.sv */
// ----------------------------------------------------------------------------
// bitmap_rect_fill_and_rotate_tb
// Drives rectangle fill and row/column rotate requests into the pixel grid,
// directed corner cases first and then random traffic, with random gaps on
// the request side and random stalls on the result side. A checker beside
// the block predicts every lit count and compares.
// ----------------------------------------------------------------------------
module bitmap_rect_fill_and_rotate_tb;
    import brfr_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int               GRID_WIDTH  = GRID_WIDTH_DEF;
    localparam int               GRID_HEIGHT = GRID_HEIGHT_DEF;
    localparam int               CYCLE_LIMIT = 200000;
    localparam logic [ACT_W-1:0] ACT_NONE    = 2'd3;

    logic             i_clk        = 1'b0;
    logic             i_rst_n      = 1'b0;
    logic             i_in_valid   = 1'b0;
    logic             o_in_stall;
    logic [ACT_W-1:0] i_action     = '0;
    logic [ARG_W-1:0] i_first_arg  = '0;
    logic [ARG_W-1:0] i_second_arg = '0;
    logic             o_out_valid;
    logic             i_out_stall  = 1'b0;
    logic [LIT_W-1:0] o_lit_count;

    logic             no_idle      = 1'b0;
    int               fail_count;
    int               pending;
    int               cycle_count  = 0;

    bitmap_rect_fill_and_rotate #(
        .GRID_WIDTH  (GRID_WIDTH),
        .GRID_HEIGHT (GRID_HEIGHT)
    ) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_action     (i_action),
        .i_first_arg  (i_first_arg),
        .i_second_arg (i_second_arg),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_lit_count  (o_lit_count)
    );

    pixel_count_checker #(
        .GRID_WIDTH  (GRID_WIDTH),
        .GRID_HEIGHT (GRID_HEIGHT)
    ) checker_i (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_in_stall   (o_in_stall),
        .i_action     (i_action),
        .i_first_arg  (i_first_arg),
        .i_second_arg (i_second_arg),
        .i_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .i_lit_count  (o_lit_count),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || no_idle) begin
            i_out_stall <= 1'b0;
        end else begin
            i_out_stall <= ($urandom_range(99) < 22);
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("bitmap_rect_fill_and_rotate test failed");
            $finish;
        end
    end

    // called at a rising edge; returns at the edge where the request is taken
    task automatic send_request(input logic [ACT_W-1:0] act,
                                input logic [ARG_W-1:0] a,
                                input logic [ARG_W-1:0] b);
        while (!no_idle && $urandom_range(99) < 22) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_action     <= act;
        i_first_arg  <= a;
        i_second_arg <= b;
        do @(posedge i_clk); while (o_in_stall);
    endtask

    initial begin
        int               pick;
        logic [ARG_W-1:0] a;
        logic [ARG_W-1:0] b;

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // zero-area rectangles, widest and tallest arguments
        send_request(ACT_RECT, 6'd0, 6'd0);
        send_request(ACT_RECT, 6'd63, 6'd0);
        send_request(ACT_RECT, 6'd0, 6'd63);
        send_request(ACT_RECT, 6'd3, 6'd2);
        // row rotates: plain, remainder zero, wrap, index outside
        send_request(ACT_ROT_ROW, 6'd0, 6'd4);
        send_request(ACT_ROT_ROW, 6'd1, 6'd50);
        send_request(ACT_ROT_ROW, 6'd0, 6'd63);
        send_request(ACT_ROT_ROW, 6'd6, 6'd1);
        send_request(ACT_ROT_ROW, 6'd63, 6'd5);
        // column rotates: plain, remainder zero, wrap, index outside
        send_request(ACT_ROT_COL, 6'd4, 6'd1);
        send_request(ACT_ROT_COL, 6'd17, 6'd6);
        send_request(ACT_ROT_COL, 6'd17, 6'd63);
        send_request(ACT_ROT_COL, 6'd50, 6'd1);
        send_request(ACT_ROT_COL, 6'd63, 6'd2);
        send_request(ACT_RECT, 6'd1, 6'd1);
        // unused action code
        send_request(ACT_NONE, 6'd63, 6'd63);
        send_request(ACT_NONE, 6'd0, 6'd0);
        // exact grid width and height
        send_request(ACT_RECT, 6'd50, 6'd1);
        send_request(ACT_ROT_COL, 6'd49, 6'd5);
        send_request(ACT_ROT_ROW, 6'd5, 6'd49);
        send_request(ACT_RECT, 6'd2, 6'd6);
        send_request(ACT_ROT_COL, 6'd0, 6'd1);
        send_request(ACT_ROT_ROW, 6'd0, 6'd0);

        // small rectangles keep the grid from filling up too early
        for (int k = 0; k < 700; k++) begin
            no_idle <= (k >= 300 && k < 420);
            pick = $urandom_range(99);
            if (pick < 7) begin
                a = ARG_W'($urandom_range(4));
                b = ARG_W'($urandom_range(3));
                send_request(ACT_RECT, a, b);
            end else if (pick < 8) begin
                a = ARG_W'($urandom_range(63));
                send_request(ACT_RECT, ($urandom_range(1) != 0) ? a : 6'd0,
                             ($urandom_range(1) != 0) ? 6'd0 : a);
            end else if (pick < 46) begin
                a = ($urandom_range(9) == 0) ? ARG_W'($urandom_range(63))
                                             : ARG_W'($urandom_range(GRID_HEIGHT - 1));
                b = ARG_W'($urandom_range(63));
                send_request(ACT_ROT_ROW, a, b);
            end else if (pick < 96) begin
                a = ($urandom_range(9) == 0) ? ARG_W'($urandom_range(63))
                                             : ARG_W'($urandom_range(GRID_WIDTH - 1));
                b = ARG_W'($urandom_range(63));
                send_request(ACT_ROT_COL, a, b);
            end else begin
                a = ARG_W'($urandom_range(63));
                b = ARG_W'($urandom_range(63));
                send_request(ACT_NONE, a, b);
            end
        end

        // full grid at the end, count reaches its largest value
        no_idle <= 1'b0;
        send_request(ACT_RECT, 6'd63, 6'd63);
        send_request(ACT_ROT_ROW, 6'd2, 6'd7);
        send_request(ACT_ROT_COL, 6'd30, 6'd3);

        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);

        if (fail_count == 0 && pending == 0) begin
            $display("bitmap_rect_fill_and_rotate test passed");
        end else begin
            $display("bitmap_rect_fill_and_rotate test failed");
        end
        $finish;
    end

endmodule
